### rtl/core/swhsr_pkg.sv
`timescale 1ns / 1ps

package swhsr_pkg;

    localparam int unsigned FRAME_BITS = 40;
    localparam int unsigned BIT_IDX_W  = 6;

    // Configuration register indexes
    localparam logic [7:0] CFG_TIMEOUT_TICKS      = 8'd0;
    localparam logic [7:0] CFG_BIT_THRESHOLD      = 8'd1;
    localparam logic [7:0] CFG_START_LOW_TICKS    = 8'd2;
    localparam logic [7:0] CFG_RELEASE_HIGH_TICKS = 8'd3;

    // Reset values of the configuration registers
    localparam logic [9:0]  RST_TIMEOUT_TICKS      = 10'd100;
    localparam logic [7:0]  RST_BIT_THRESHOLD      = 8'd40;
    localparam logic [15:0] RST_START_LOW_TICKS    = 16'd2000;
    localparam logic [7:0]  RST_RELEASE_HIGH_TICKS = 8'd30;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Line modes
    localparam logic [1:0] LINE_RELEASED   = 2'd0;
    localparam logic [1:0] LINE_DRIVE_LOW  = 2'd1;
    localparam logic [1:0] LINE_DRIVE_HIGH = 2'd2;

    // Read status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

    typedef struct packed {
        logic command;
        logic pin_level;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         line_mode;
        logic               busy_res;
        logic               done_res;
        logic [1:0]         status;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
    } t_out_item;

endpackage

### rtl/core/single_wire_humidity_sensor_reader_unit.sv
`timescale 1ns / 1ps

// Single-wire temperature and humidity sensor reader. Each input transaction is
// either a start command or one microsecond tick carrying the sampled pin level;
// every input transaction yields exactly one result transaction with the line
// drive mode, busy and done flags, the status of the last read and the humidity
// and temperature of the last good read. A start drives the line low for
// start_low_ticks ticks, high for release_high_ticks ticks, then releases it and
// times the sensor's response and 40 data bits, checking the byte checksum at the
// end. One transaction is taken every clock cycle unless the input is stalled; the
// phase, counters and frame shift register are updated together and the result
// goes into an output register backed by a one-entry skid register, so input
// stall is registered and rises only once both are full. Configuration writes are
// always ready and take effect on the next cycle; write them only while no read runs.
module single_wire_humidity_sensor_reader_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  swhsr_pkg::t_in_item  i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output swhsr_pkg::t_out_item o_out_data,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DRIVE_LOW,
        PH_DRIVE_HIGH,
        PH_WAIT_LOW0,
        PH_WAIT_HIGH0,
        PH_BIT_LOW,
        PH_BIT_HIGH
    } t_phase;

    localparam logic [swhsr_pkg::BIT_IDX_W-1:0] LAST_BIT =
        swhsr_pkg::BIT_IDX_W'(swhsr_pkg::FRAME_BITS);

    // configuration
    logic [9:0]  r_timeout_ticks;
    logic [7:0]  r_bit_threshold;
    logic [15:0] r_start_low_ticks;
    logic [7:0]  r_release_high_ticks;

    // read state
    t_phase                             r_phase,   n_phase;
    logic [15:0]                        r_tick,    n_tick;
    logic [swhsr_pkg::BIT_IDX_W-1:0]    r_bit_idx, n_bit_idx;
    logic [swhsr_pkg::FRAME_BITS-1:0]   r_frame,   n_frame;
    logic [1:0]                         r_status,  n_status;
    logic [15:0]                        r_hum,     n_hum;
    logic [15:0]                        r_temp,    n_temp;
    logic                               n_done;

    // output register and skid register
    logic                 r_out_valid;
    logic                 r_skid_valid;
    swhsr_pkg::t_out_item r_out;
    swhsr_pkg::t_out_item r_skid;
    swhsr_pkg::t_out_item n_result;

    logic in_accept;
    logic out_take;
    logic cfg_write;

    // next-state helpers
    logic        level;
    logic [15:0] tick_inc;
    logic [15:0] tick_sat;
    logic        bit_val;
    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  sum;
    logic [15:0] raw_temp;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign cfg_write  = i_cfg_valid && o_cfg_ready;

    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign level    = !((r_phase == PH_WAIT_LOW0) || (r_phase == PH_BIT_LOW));
    assign tick_inc = r_tick + 16'd1;
    assign tick_sat = (r_tick == 16'hFFFF) ? r_tick : tick_inc;
    assign bit_val  = (r_tick > {8'd0, r_bit_threshold});

    // frame after shifting in the bit of the high phase now ending
    assign b0 = n_frame[39:32];
    assign b1 = n_frame[31:24];
    assign b2 = n_frame[23:16];
    assign b3 = n_frame[15:8];
    assign b4 = n_frame[7:0];
    assign sum      = b0 + b1 + b2 + b3;
    assign raw_temp = {b2, b3};

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit_idx = r_bit_idx;
        n_frame   = r_frame;
        n_status  = r_status;
        n_hum     = r_hum;
        n_temp    = r_temp;
        n_done    = 1'b0;

        if (i_in_data.command == swhsr_pkg::CMD_START) begin
            if (r_phase == PH_IDLE) begin
                n_phase   = PH_DRIVE_LOW;
                n_tick    = '0;
                n_bit_idx = '0;
                n_frame   = '0;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_DRIVE_LOW: begin
                    n_tick = tick_inc;
                    if (tick_inc >= r_start_low_ticks) begin
                        n_phase = PH_DRIVE_HIGH;
                        n_tick  = '0;
                    end
                end
                PH_DRIVE_HIGH: begin
                    n_tick = tick_inc;
                    if (tick_inc >= {8'd0, r_release_high_ticks}) begin
                        n_phase = PH_WAIT_LOW0;
                        n_tick  = '0;
                    end
                end
                PH_WAIT_LOW0, PH_WAIT_HIGH0, PH_BIT_LOW, PH_BIT_HIGH: begin
                    if (i_in_data.pin_level == level) begin
                        n_tick = tick_sat;
                        if (tick_sat > {6'd0, r_timeout_ticks}) begin
                            n_phase  = PH_IDLE;
                            n_tick   = '0;
                            n_status = swhsr_pkg::STATUS_TIMEOUT;
                            n_done   = 1'b1;
                        end
                    end else begin
                        // the edge sample counts as the first tick of the next phase
                        n_tick = 16'd1;
                        unique case (r_phase)
                            PH_WAIT_LOW0:  n_phase = PH_WAIT_HIGH0;
                            PH_WAIT_HIGH0: n_phase = PH_BIT_LOW;
                            PH_BIT_LOW:    n_phase = PH_BIT_HIGH;
                            default: begin
                                n_frame   = {r_frame[swhsr_pkg::FRAME_BITS-2:0], bit_val};
                                n_bit_idx = r_bit_idx + 1'b1;
                                n_phase   = PH_BIT_LOW;
                            end
                        endcase
                        if ((r_phase == PH_BIT_HIGH) && (n_bit_idx >= LAST_BIT)) begin
                            n_phase = PH_IDLE;
                            n_tick  = '0;
                            n_done  = 1'b1;
                            if (sum != b4) begin
                                n_status = swhsr_pkg::STATUS_CHECKSUM;
                            end else begin
                                n_status = swhsr_pkg::STATUS_OK;
                                n_hum    = {b0, b1};
                                n_temp   = raw_temp[15] ? (16'd0 - {1'b0, raw_temp[14:0]})
                                                        : raw_temp;
                            end
                        end else if (r_timeout_ticks == 10'd0) begin
                            n_phase  = PH_IDLE;
                            n_tick   = '0;
                            n_status = swhsr_pkg::STATUS_TIMEOUT;
                            n_done   = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        n_result.line_mode = (n_phase == PH_DRIVE_LOW)  ? swhsr_pkg::LINE_DRIVE_LOW  :
                             (n_phase == PH_DRIVE_HIGH) ? swhsr_pkg::LINE_DRIVE_HIGH :
                                                          swhsr_pkg::LINE_RELEASED;
        n_result.busy_res    = (n_phase != PH_IDLE);
        n_result.done_res    = n_done;
        n_result.status      = n_status;
        n_result.humidity    = n_hum;
        n_result.temperature = n_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks      <= swhsr_pkg::RST_TIMEOUT_TICKS;
            r_bit_threshold      <= swhsr_pkg::RST_BIT_THRESHOLD;
            r_start_low_ticks    <= swhsr_pkg::RST_START_LOW_TICKS;
            r_release_high_ticks <= swhsr_pkg::RST_RELEASE_HIGH_TICKS;
            r_phase              <= PH_IDLE;
            r_tick               <= '0;
            r_bit_idx            <= '0;
            r_frame              <= '0;
            r_status             <= swhsr_pkg::STATUS_OK;
            r_hum                <= '0;
            r_temp               <= '0;
            r_out_valid          <= 1'b0;
            r_skid_valid         <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (i_cfg_index)
                    swhsr_pkg::CFG_TIMEOUT_TICKS:      r_timeout_ticks      <= i_cfg_data[9:0];
                    swhsr_pkg::CFG_BIT_THRESHOLD:      r_bit_threshold      <= i_cfg_data[7:0];
                    swhsr_pkg::CFG_START_LOW_TICKS:    r_start_low_ticks    <= i_cfg_data;
                    swhsr_pkg::CFG_RELEASE_HIGH_TICKS: r_release_high_ticks <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end

            if (in_accept) begin
                r_phase   <= n_phase;
                r_tick    <= n_tick;
                r_bit_idx <= n_bit_idx;
                r_frame   <= n_frame;
                r_status  <= n_status;
                r_hum     <= n_hum;
                r_temp    <= n_temp;
            end

            // output register with skid: the skid fills only while the output is held
            if (out_take) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_accept;
                    if (in_accept) begin
                        r_out <= n_result;
                    end
                end
            end else if (in_accept) begin
                if (!r_out_valid) begin
                    r_out       <= n_result;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_result;
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a transaction while the output register is empty");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("read finished but result still reports busy");

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.busy_res) |-> (r_out.line_mode == swhsr_pkg::LINE_RELEASED))
        else $error("line driven while no read is in progress");

    a_bit_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BIT_LOW || r_phase == PH_BIT_HIGH) |-> (r_bit_idx < LAST_BIT))
        else $error("bit index past end of frame during bit phases");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef enum logic [3:0] {
        RD_IDLE, RD_DRIVE_LOW, RD_DRIVE_HIGH, RD_WAIT_LOW0, RD_WAIT_HIGH0, RD_BIT_LOW, RD_BIT_HIGH
    } t_rd_phase;

    typedef struct packed {
        t_rd_phase   ph;
        logic [15:0] cnt;
        logic [5:0]  nbits;
        logic [39:0] frame;
        logic [1:0]  stat;
        logic [15:0] hum;
        logic [15:0] temp;
    } t_rd_state;

    typedef struct packed {
        logic [9:0]  timeout;
        logic [7:0]  thr;
        logic [15:0] low_len;
        logic [7:0]  high_len;
    } t_rd_cfg;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_vld = 1'b0;
    logic                 in_stall;
    swhsr_pkg::t_in_item  in_item = '0;
    logic                 out_vld;
    logic                 out_stall = 1'b0;
    swhsr_pkg::t_out_item out_item;
    logic                 cfg_vld = 1'b0;
    logic                 cfg_rdy;
    logic [7:0]           cfg_idx = '0;
    logic [15:0]          cfg_dat = '0;

    single_wire_humidity_sensor_reader_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_vld),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_vld),
        .i_out_stall (out_stall),
        .o_out_data  (out_item),
        .i_cfg_valid (cfg_vld),
        .o_cfg_ready (cfg_rdy),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_dat)
    );

    // Reader state and settings: one copy for the checker, one for planning stimulus
    t_rd_state sensor_chk, sensor_plan;
    t_rd_cfg   cfg_chk, cfg_plan;

    swhsr_pkg::t_in_item  pending_q[$];
    swhsr_pkg::t_out_item sensor_out_q[$];

    int unsigned send_idle_pct = 0, recv_idle_pct = 0;
    int unsigned send_calm = 0, recv_calm = 0;
    logic        in_taken = 1'b0;
    logic        hold_go = 1'b0, hold_used = 1'b0;
    int unsigned hold_left = 0;

    int unsigned errors = 0, cycles = 0, plan_items = 0, n_items = 0, n_cfg = 0;
    int unsigned n_ok = 0, n_timeout = 0, n_badsum = 0, n_held = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void apply_reg(inout t_rd_cfg c, input logic [7:0] idx,
                                      input logic [15:0] val);
        case (idx)
            swhsr_pkg::CFG_TIMEOUT_TICKS:      c.timeout  = val[9:0];
            swhsr_pkg::CFG_BIT_THRESHOLD:      c.thr      = val[7:0];
            swhsr_pkg::CFG_START_LOW_TICKS:    c.low_len  = val;
            swhsr_pkg::CFG_RELEASE_HIGH_TICKS: c.high_len = val[7:0];
            default: ;
        endcase
    endfunction

    task automatic advance_sensor_read(inout t_rd_state s, input t_rd_cfg c,
                                       input swhsr_pkg::t_in_item it,
                                       output swhsr_pkg::t_out_item r);
        logic       lvl, done, ended, framed;
        logic [1:0] end_code;
        logic [7:0] sum;
        logic [15:0] raw;
        done = 1'b0;
        ended = 1'b0;
        framed = 1'b0;
        end_code = swhsr_pkg::STATUS_OK;
        if (it.command == swhsr_pkg::CMD_START) begin
            // a start during a read is dropped
            if (s.ph == RD_IDLE) begin
                s.ph = RD_DRIVE_LOW;
                s.cnt = '0;
                s.nbits = '0;
                s.frame = '0;
            end
        end else begin
            case (s.ph)
                RD_IDLE: ;
                RD_DRIVE_LOW: begin
                    s.cnt = s.cnt + 16'd1;
                    if (s.cnt >= c.low_len) begin
                        s.ph = RD_DRIVE_HIGH;
                        s.cnt = '0;
                    end
                end
                RD_DRIVE_HIGH: begin
                    s.cnt = s.cnt + 16'd1;
                    if (s.cnt >= c.high_len) begin
                        s.ph = RD_WAIT_LOW0;
                        s.cnt = '0;
                    end
                end
                default: begin
                    lvl = (s.ph == RD_WAIT_LOW0 || s.ph == RD_BIT_LOW) ? 1'b0 : 1'b1;
                    if (it.pin_level != lvl) begin
                        case (s.ph)
                            RD_WAIT_LOW0:  s.ph = RD_WAIT_HIGH0;
                            RD_WAIT_HIGH0: s.ph = RD_BIT_LOW;
                            RD_BIT_LOW:    s.ph = RD_BIT_HIGH;
                            default: begin
                                s.frame = {s.frame[38:0], (s.cnt > c.thr)};
                                s.nbits = s.nbits + 6'd1;
                                if (s.nbits >= swhsr_pkg::FRAME_BITS) framed = 1'b1;
                                else s.ph = RD_BIT_LOW;
                            end
                        endcase
                        s.cnt = '0;
                    end
                    if (framed) begin
                        sum = s.frame[39:32] + s.frame[31:24] + s.frame[23:16] + s.frame[15:8];
                        ended = 1'b1;
                        if (sum != s.frame[7:0]) begin
                            end_code = swhsr_pkg::STATUS_CHECKSUM;
                        end else begin
                            s.hum = s.frame[39:24];
                            raw = s.frame[23:8];
                            // sign-magnitude to two's complement
                            s.temp = raw[15] ? 16'h0000 - {1'b0, raw[14:0]} : raw;
                        end
                    end else begin
                        // the changed sample counts as the first tick of the next phase
                        if (s.cnt != 16'hFFFF) s.cnt = s.cnt + 16'd1;
                        if (s.cnt > c.timeout) begin
                            ended = 1'b1;
                            end_code = swhsr_pkg::STATUS_TIMEOUT;
                        end
                    end
                end
            endcase
        end
        if (ended) begin
            s.ph = RD_IDLE;
            s.cnt = '0;
            s.stat = end_code;
            done = 1'b1;
        end
        r.line_mode = (s.ph == RD_DRIVE_LOW)  ? swhsr_pkg::LINE_DRIVE_LOW :
                      (s.ph == RD_DRIVE_HIGH) ? swhsr_pkg::LINE_DRIVE_HIGH :
                                                swhsr_pkg::LINE_RELEASED;
        r.busy_res = (s.ph != RD_IDLE);
        r.done_res = done;
        r.status = s.stat;
        r.humidity = s.hum;
        r.temperature = s.temp;
    endtask

    task automatic flag_result(input string what, input swhsr_pkg::t_out_item want,
                               input swhsr_pkg::t_out_item got);
        errors++;
        if (errors <= 10)
            $display("mismatch %0d (%s) at %0t: expected mode=%0d busy=%0b done=%0b st=%0d hum=%h temp=%0d, got mode=%0d busy=%0b done=%0b st=%0d hum=%h temp=%0d",
                     errors, what, $time, want.line_mode, want.busy_res, want.done_res,
                     want.status, want.humidity, want.temperature, got.line_mode,
                     got.busy_res, got.done_res, got.status, got.humidity, got.temperature);
    endtask

    // Checker: predict on input transactions, compare result transactions
    always @(posedge clk) begin
        swhsr_pkg::t_out_item want;
        in_taken <= in_vld && !in_stall;
        if (rst_n) begin
            if (out_vld && !out_stall) begin
                if (sensor_out_q.size() == 0) begin
                    flag_result("no result expected", '0, out_item);
                end else begin
                    want = sensor_out_q.pop_front();
                    if (out_item.line_mode !== want.line_mode ||
                        out_item.busy_res !== want.busy_res ||
                        out_item.done_res !== want.done_res ||
                        out_item.status !== want.status ||
                        out_item.humidity !== want.humidity ||
                        out_item.temperature !== want.temperature)
                        flag_result("field differs", want, out_item);
                end
            end
            if (in_vld && !in_stall) begin
                advance_sensor_read(sensor_chk, cfg_chk, in_item, want);
                sensor_out_q.push_back(want);
                n_items++;
                if (want.done_res) begin
                    case (want.status)
                        swhsr_pkg::STATUS_OK:      n_ok++;
                        swhsr_pkg::STATUS_TIMEOUT: n_timeout++;
                        default:                   n_badsum++;
                    endcase
                end
            end
            if (in_vld && in_stall) n_held++;
            if (cfg_vld && cfg_rdy) begin
                apply_reg(cfg_chk, cfg_idx, cfg_dat);
                n_cfg++;
            end
        end
    end

    // Input driver: advance only once the current transaction has gone
    always @(negedge clk) begin
        if (rst_n && (!in_vld || in_taken)) begin
            if (send_calm != 0) send_calm <= send_calm - 1;
            else if ($urandom_range(199) == 0) send_calm <= $urandom_range(80, 20);
            if (pending_q.size() != 0 &&
                (send_calm != 0 || $urandom_range(99) >= send_idle_pct)) begin
                in_item <= pending_q.pop_front();
                in_vld <= 1'b1;
            end else begin
                in_vld <= 1'b0;
            end
        end
    end

    // Result stall: random, with one long hold-off when asked
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= 400;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (recv_calm != 0) begin
            recv_calm <= recv_calm - 1;
            out_stall <= 1'b0;
        end else begin
            if ($urandom_range(199) == 0) recv_calm <= $urandom_range(80, 20);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     sensor_out_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_item(input logic cmd, input logic pin);
        swhsr_pkg::t_in_item  it;
        swhsr_pkg::t_out_item ignored;
        it.command = cmd;
        it.pin_level = pin;
        pending_q.push_back(it);
        advance_sensor_read(sensor_plan, cfg_plan, it, ignored);
        plan_items++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_vld <= 1'b1;
        cfg_idx <= idx;
        cfg_dat <= val;
        do @(posedge clk); while (!cfg_rdy);
        apply_reg(cfg_plan, idx, val);
        @(negedge clk);
        cfg_vld <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (pending_q.size() != 0 || in_vld || sensor_out_q.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    function automatic int pick(input int lo, input int hi);
        if (hi < lo) return (hi >= 1) ? hi : lo;
        return $urandom_range(hi, lo);
    endfunction

    task automatic start_read();
        push_item(swhsr_pkg::CMD_START, 1'($urandom_range(1)));
        // pin is don't-care while the line is driven
        while (sensor_plan.ph == RD_DRIVE_LOW || sensor_plan.ph == RD_DRIVE_HIGH) begin
            if ($urandom_range(29) == 0)
                push_item(swhsr_pkg::CMD_START, 1'($urandom_range(1)));
            push_item(swhsr_pkg::CMD_TICK, 1'($urandom_range(1)));
        end
    endtask

    task automatic pin_run(input logic lvl, input int n);
        for (int k = 0; k < n && sensor_plan.ph != RD_IDLE; k++) begin
            if ($urandom_range(49) == 0)
                push_item(swhsr_pkg::CMD_START, 1'($urandom_range(1)));
            push_item(swhsr_pkg::CMD_TICK, lvl);
        end
    endtask

    // Runs: lead-in low, lead-in high, then low/high per bit; a run of timeout+1 at
    // position cut_at breaks the read
    task automatic send_frame(input logic [39:0] bits, input int cut_at);
        int to, thr, cap, len;
        to = cfg_plan.timeout;
        thr = cfg_plan.thr;
        cap = (to < 3) ? to : 3;
        start_read();
        for (int r = 0; r < 2 + 2 * swhsr_pkg::FRAME_BITS; r++) begin
            if (r == cut_at) len = to + 1;
            else if (r == 0) len = pick(0, cap);
            else if (r == 1 || r % 2 == 0) len = pick(1, cap);
            else if (bits[swhsr_pkg::FRAME_BITS - 1 - (r - 3) / 2])
                len = pick(thr + 1, (to < thr + 3) ? to : thr + 3);
            else
                len = pick((thr > 3) ? thr - 2 : 1, (to < thr) ? to : thr);
            pin_run(r % 2 != 0, len);
        end
        pin_run(1'b0, 1);
    endtask

    function automatic logic [39:0] build_frame(input logic [15:0] hum, input logic [15:0] raw,
                                                input logic good);
        logic [7:0] sum, spoil;
        sum = hum[15:8] + hum[7:0] + raw[15:8] + raw[7:0];
        spoil = 8'($urandom_range(255, 1));
        return {hum, raw, good ? sum : sum ^ spoil};
    endfunction

    task automatic settle_idle();
        // hold the awaited level so any open phase times out
        while (sensor_plan.ph != RD_IDLE)
            push_item(swhsr_pkg::CMD_TICK,
                      !(sensor_plan.ph == RD_WAIT_LOW0 || sensor_plan.ph == RD_BIT_LOW));
    endtask

    task automatic random_reads(input int unsigned quota);
        int unsigned stop_at, kind, n;
        stop_at = plan_items + quota;
        while (plan_items < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                send_frame(build_frame(16'($urandom), 16'($urandom), $urandom_range(9) != 0),
                           -1);
            end else if (kind < 85) begin
                send_frame(build_frame(16'($urandom), 16'($urandom), 1'b1),
                           $urandom_range(1 + 2 * swhsr_pkg::FRAME_BITS));
            end else begin
                n = $urandom_range(30, 5);
                repeat (n) push_item($urandom_range(5) == 0, 1'($urandom_range(1)));
            end
            settle_idle();
        end
    endtask

    task automatic set_idling(input int unsigned snd, input int unsigned rcv);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
    endtask

    initial begin
        sensor_chk = '{RD_IDLE, 16'd0, 6'd0, 40'd0, swhsr_pkg::STATUS_OK, 16'd0, 16'd0};
        sensor_plan = sensor_chk;
        cfg_chk = '{swhsr_pkg::RST_TIMEOUT_TICKS, swhsr_pkg::RST_BIT_THRESHOLD,
                    swhsr_pkg::RST_START_LOW_TICKS, swhsr_pkg::RST_RELEASE_HIGH_TICKS};
        cfg_plan = cfg_chk;
        set_idling(12, 63);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle ticks out of reset, then a low wait that runs past the reset timeout
        repeat (4) push_item(swhsr_pkg::CMD_TICK, 1'($urandom_range(1)));
        wait_drained();
        write_reg(swhsr_pkg::CFG_START_LOW_TICKS, 16'd3);
        write_reg(swhsr_pkg::CFG_RELEASE_HIGH_TICKS, 16'd2);
        start_read();
        pin_run(1'b0, 120);
        wait_drained();

        write_reg(swhsr_pkg::CFG_TIMEOUT_TICKS, 16'hFC02);
        write_reg(swhsr_pkg::CFG_BIT_THRESHOLD, 16'd1);
        write_reg(swhsr_pkg::CFG_START_LOW_TICKS, 16'd0);
        write_reg(swhsr_pkg::CFG_RELEASE_HIGH_TICKS, 16'd0);
        write_reg(8'd4, 16'h0001);
        write_reg(8'hFF, 16'hFFFF);
        send_frame(build_frame(16'h0000, 16'h8000, 1'b1), -1);
        push_item(swhsr_pkg::CMD_TICK, 1'b1);
        send_frame(build_frame(16'hABCD, 16'h80FA, 1'b0), -1);
        send_frame(build_frame(16'h5555, 16'h00AA, 1'b1), 0);
        send_frame(build_frame(16'h5555, 16'h00AA, 1'b1), 1);
        send_frame(build_frame(16'h5555, 16'h00AA, 1'b1), 2 + 2 * 17);
        send_frame(build_frame(16'h5555, 16'h00AA, 1'b1), 1 + 2 * swhsr_pkg::FRAME_BITS);
        settle_idle();
        wait_drained();

        write_reg(swhsr_pkg::CFG_TIMEOUT_TICKS, 16'd0);
        send_frame(build_frame(16'h0102, 16'h0304, 1'b1), -1);
        settle_idle();
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            if (p == 1) set_idling(63, 12);
            if (p == 2) set_idling(0, 0);
            write_reg(swhsr_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(6, 3)));
            write_reg(swhsr_pkg::CFG_BIT_THRESHOLD, 16'($urandom_range(3, 0)));
            write_reg(swhsr_pkg::CFG_START_LOW_TICKS, 16'($urandom_range(4, 1)));
            write_reg(swhsr_pkg::CFG_RELEASE_HIGH_TICKS, 16'($urandom_range(4, 1)));
            if ($urandom_range(2) == 0)
                write_reg(8'($urandom_range(255, 4)), 16'($urandom));
            random_reads(120);
            // long hold-off on results while input keeps coming
            if (p == 2) hold_go = 1'b1;
            wait_drained();
        end
        repeat (20) @(posedge clk);

        $display("covered %0d transactions and %0d register writes; reads: %0d good, %0d timed out, %0d bad checksum",
                 n_items, n_cfg, n_ok, n_timeout, n_badsum);
        $display("input held off for %0d cycles; %0d mismatches", n_held, errors);
        if (errors == 0 && sensor_out_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/swhsr_pkg.sv
rtl/core/single_wire_humidity_sensor_reader_unit.sv
dv/tb_top.sv
